>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the gesture block.
// No dependencies; the including scope must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define TFZ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define TFZ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/tfz_pkg.sv
// Shared types, codes and constants of the three-finger zoom recognizer.
// No dependencies.
package tfz_pkg;

    localparam int TFZ_COORD_BITS = 16;
    localparam int NUM_SLOTS      = 3;
    localparam int SLOT_IDX_W     = 2;
    localparam int THR_W          = 16;

    localparam logic [3:0] MAX_FINGERS = 4'd15;
    localparam logic [3:0] START_COUNT = 4'd3;

    localparam logic [THR_W-1:0] THR_RESET = 16'd240;

    // Configuration register indexes.
    localparam logic CFG_STEP_THR  = 1'b0;
    localparam logic CFG_TOTAL_THR = 1'b1;

    // Event kinds.
    localparam logic [2:0] FUNC_DOWN   = 3'd0;
    localparam logic [2:0] FUNC_MOTION = 3'd1;
    localparam logic [2:0] FUNC_UP     = 3'd2;
    localparam logic [2:0] FUNC_FRAME  = 3'd3;
    localparam logic [2:0] FUNC_CANCEL = 3'd4;

    // Verdicts.
    localparam logic [2:0] V_IGNORE    = 3'd0;
    localparam logic [2:0] V_MAYBE     = 3'd1;
    localparam logic [2:0] V_UPDATE    = 3'd2;
    localparam logic [2:0] V_FINISHED  = 3'd3;
    localparam logic [2:0] V_CANCELLED = 3'd4;

    // Directions.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_IN   = 2'd1;
    localparam logic [1:0] DIR_OUT  = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  slot;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] verdict;
        logic [1:0] last_dir;
        logic [1:0] total_dir;
        logic [3:0] fingers;
    } t_out_beat;

endpackage

>>> hw/rtl/tfz_dist.sv
// Doubled Manhattan distance from point 1 to the midpoint of points 0 and 2.
// Depends on tfz_pkg.
module tfz_dist import tfz_pkg::*; #(
    parameter int COORD_BITS = TFZ_COORD_BITS
) (
    input  logic [COORD_BITS-1:0] i_x [NUM_SLOTS],
    input  logic [COORD_BITS-1:0] i_y [NUM_SLOTS],
    output logic [COORD_BITS+1:0] o_dist
);

    localparam int SW = COORD_BITS + 2;
    localparam int AW = COORD_BITS + 1;

    logic signed [SW-1:0] w_dx;
    logic signed [SW-1:0] w_dy;
    logic [AW-1:0]        w_ax;
    logic [AW-1:0]        w_ay;

    assign w_dx = $signed(SW'(i_x[0])) + $signed(SW'(i_x[2]))
                - $signed({1'b0, i_x[1], 1'b0});
    assign w_dy = $signed(SW'(i_y[0])) + $signed(SW'(i_y[2]))
                - $signed({1'b0, i_y[1], 1'b0});

    assign w_ax = w_dx[SW-1] ? AW'(-w_dx) : AW'(w_dx);
    assign w_ay = w_dy[SW-1] ? AW'(-w_dy) : AW'(w_dy);

    assign o_dist = SW'(w_ax) + SW'(w_ay);

endmodule

>>> hw/rtl/tfz_core.sv
// Gesture state and per-event decision logic; one event per enabled cycle.
// Depends on tfz_pkg and tfz_dist.
module tfz_core import tfz_pkg::*; #(
    parameter int COORD_BITS = TFZ_COORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_in_beat         i_beat,
    input  logic [THR_W-1:0] i_step_thr,
    input  logic [THR_W-1:0] i_total_thr,
    output t_out_beat        o_beat
);

    localparam int C  = COORD_BITS;
    localparam int MW = (C > 16) ? C : 16;
    localparam int DW = C + 2;
    localparam int SW = ((C + 3) > (THR_W + 3)) ? (C + 3) : (THR_W + 3);

    typedef logic [C-1:0] t_coord;

    logic [3:0] r_fc, n_fc;
    logic       r_canc, n_canc;
    logic       r_started, n_started;
    logic [1:0] r_dir, n_dir;
    t_coord     r_start_x [NUM_SLOTS], n_start_x [NUM_SLOTS];
    t_coord     r_start_y [NUM_SLOTS], n_start_y [NUM_SLOTS];
    t_coord     r_last_x  [NUM_SLOTS], n_last_x  [NUM_SLOTS];
    t_coord     r_last_y  [NUM_SLOTS], n_last_y  [NUM_SLOTS];
    t_coord     r_cur_x   [NUM_SLOTS], n_cur_x   [NUM_SLOTS];
    t_coord     r_cur_y   [NUM_SLOTS], n_cur_y   [NUM_SLOTS];

    logic [MW-1:0]         w_wide_x, w_wide_y;
    t_coord                w_px, w_py;
    logic                  w_slot_ok;
    logic [SLOT_IDX_W-1:0] w_sidx;
    logic [3:0]            w_fc_inc, w_fc_dec;
    logic [2:0]            w_verdict;
    logic                  w_clear_after;
    logic [1:0]            w_total_dir;

    logic [DW-1:0]        w_dist_cur, w_dist_last, w_dist_ncur, w_dist_nstart;
    logic signed [SW-1:0] w_d_frame, w_d_total, w_t2;
    logic [SW-1:0]        w_abs_frame;
    logic                 w_frame_big;

    assign w_wide_x  = MW'(i_beat.pos_x);
    assign w_wide_y  = MW'(i_beat.pos_y);
    assign w_px      = w_wide_x[C-1:0];
    assign w_py      = w_wide_y[C-1:0];
    assign w_slot_ok = i_beat.slot < 4'(NUM_SLOTS);
    assign w_sidx    = i_beat.slot[SLOT_IDX_W-1:0];
    assign w_fc_inc  = (r_fc < MAX_FINGERS) ? r_fc + 4'd1 : r_fc;
    assign w_fc_dec  = (r_fc != 4'd0) ? r_fc - 4'd1 : r_fc;

    // Frame test works on the stored points, before this event.
    tfz_dist #(.COORD_BITS(C)) u_dist_cur (
        .i_x(r_cur_x), .i_y(r_cur_y), .o_dist(w_dist_cur)
    );
    tfz_dist #(.COORD_BITS(C)) u_dist_last (
        .i_x(r_last_x), .i_y(r_last_y), .o_dist(w_dist_last)
    );

    assign w_d_frame   = $signed(SW'(w_dist_cur)) - $signed(SW'(w_dist_last));
    assign w_abs_frame = w_d_frame[SW-1] ? SW'(-w_d_frame) : SW'(w_d_frame);
    assign w_frame_big = w_abs_frame >= SW'({i_step_thr, 1'b0});

    always_comb begin
        n_fc          = r_fc;
        n_canc        = r_canc;
        n_started     = r_started;
        n_dir         = r_dir;
        n_start_x     = r_start_x;
        n_start_y     = r_start_y;
        n_last_x      = r_last_x;
        n_last_y      = r_last_y;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        w_verdict     = V_IGNORE;
        w_clear_after = 1'b0;

        unique case (i_beat.func)
            FUNC_DOWN: begin
                n_fc = w_fc_inc;
                if (!r_canc) begin
                    if (w_fc_inc <= START_COUNT && w_slot_ok) begin
                        n_start_x[w_sidx] = w_px;
                        n_start_y[w_sidx] = w_py;
                    end
                    if (w_fc_inc == START_COUNT) begin
                        n_started = 1'b1;
                        n_last_x  = n_start_x;
                        n_last_y  = n_start_y;
                        n_cur_x   = n_start_x;
                        n_cur_y   = n_start_y;
                        w_verdict = V_MAYBE;
                    end else if (w_fc_inc > START_COUNT) begin
                        n_canc    = 1'b1;
                        w_verdict = V_CANCELLED;
                    end
                end
            end
            FUNC_MOTION: begin
                if (!r_canc && r_started && w_slot_ok) begin
                    n_cur_x[w_sidx] = w_px;
                    n_cur_y[w_sidx] = w_py;
                end
            end
            FUNC_UP: begin
                n_fc = w_fc_dec;
                if (w_fc_dec == 4'd0) begin
                    if (!r_canc && r_started && r_dir != DIR_NONE) begin
                        w_verdict     = V_FINISHED;
                        w_clear_after = 1'b1;
                    end else begin
                        // Clear before reporting, so both directions read as none.
                        n_canc    = 1'b0;
                        n_started = 1'b0;
                        n_dir     = DIR_NONE;
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            n_start_x[i] = '0;
                            n_start_y[i] = '0;
                            n_last_x[i]  = '0;
                            n_last_y[i]  = '0;
                            n_cur_x[i]   = '0;
                            n_cur_y[i]   = '0;
                        end
                    end
                end
            end
            FUNC_FRAME: begin
                if (!r_canc && r_started && w_frame_big) begin
                    n_last_x  = r_cur_x;
                    n_last_y  = r_cur_y;
                    // Only a strictly growing spread is zoom in; no change counts as out.
                    n_dir     = (!w_d_frame[SW-1] && w_d_frame != '0) ? DIR_IN : DIR_OUT;
                    w_verdict = V_UPDATE;
                end
            end
            FUNC_CANCEL: begin
                n_canc    = 1'b1;
                w_verdict = V_CANCELLED;
            end
            default: begin
            end
        endcase
    end

    // Total direction is reported on the points as this event leaves them.
    tfz_dist #(.COORD_BITS(C)) u_dist_ncur (
        .i_x(n_cur_x), .i_y(n_cur_y), .o_dist(w_dist_ncur)
    );
    tfz_dist #(.COORD_BITS(C)) u_dist_nstart (
        .i_x(n_start_x), .i_y(n_start_y), .o_dist(w_dist_nstart)
    );

    assign w_d_total = $signed(SW'(w_dist_ncur)) - $signed(SW'(w_dist_nstart));
    assign w_t2      = $signed(SW'({i_total_thr, 1'b0}));

    always_comb begin
        if (w_d_total > w_t2) begin
            w_total_dir = DIR_IN;
        end else if (w_d_total < -w_t2) begin
            w_total_dir = DIR_OUT;
        end else begin
            w_total_dir = DIR_NONE;
        end
    end

    assign o_beat = '{verdict: w_verdict, last_dir: n_dir, total_dir: w_total_dir,
                      fingers: n_fc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc      <= 4'd0;
            r_canc    <= 1'b0;
            r_started <= 1'b0;
            r_dir     <= DIR_NONE;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_start_x[i] <= '0;
                r_start_y[i] <= '0;
                r_last_x[i]  <= '0;
                r_last_y[i]  <= '0;
                r_cur_x[i]   <= '0;
                r_cur_y[i]   <= '0;
            end
        end else if (i_fire) begin
            r_fc <= n_fc;
            if (w_clear_after) begin
                r_canc    <= 1'b0;
                r_started <= 1'b0;
                r_dir     <= DIR_NONE;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    r_start_x[i] <= '0;
                    r_start_y[i] <= '0;
                    r_last_x[i]  <= '0;
                    r_last_y[i]  <= '0;
                    r_cur_x[i]   <= '0;
                    r_cur_y[i]   <= '0;
                end
            end else begin
                r_canc    <= n_canc;
                r_started <= n_started;
                r_dir     <= n_dir;
                r_start_x <= n_start_x;
                r_start_y <= n_start_y;
                r_last_x  <= n_last_x;
                r_last_y  <= n_last_y;
                r_cur_x   <= n_cur_x;
                r_cur_y   <= n_cur_y;
            end
        end
    end

endmodule

>>> hw/rtl/three_finger_zoom_gesture_recognizer.sv
// Three-finger zoom gesture recognizer, top level.
// Depends on tfz_pkg, tfz_core and tfz_dist.
//
// Usage:
//   Touch events enter on the input channel (i_in_valid / o_in_stall /
//   i_in_data); one result beat leaves on the output channel (o_out_valid /
//   i_out_stall / o_out_data) for every event, in order.
//   A beat moves at a rising edge with valid high and stall low.
//   An accepted event waits in the event register; its result is loaded into the
//   result register when it fires. Throughput is one event per cycle unless the
//   receiver stalls: the event register feeds combinational decision logic whose
//   state updates at the same edge that loads the result register.
//   When the receiver stalls, the result register holds its beat; one more
//   event waits in the event register, and then o_in_stall rises until the
//   result is taken.
//   Thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
//   must write them only while the block is idle, which the block does not enforce.
//   Synchronous active-low reset empties both registers, zeroes the finger
//   count and the gesture state, and sets both thresholds to 240.
module three_finger_zoom_gesture_recognizer import tfz_pkg::*; #(
    parameter int COORD_BITS = TFZ_COORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [THR_W-1:0] i_cfg_data
);

    logic             r_s1_valid;
    t_in_beat         r_s1_data;
    logic             r_out_valid;
    t_out_beat        r_out_data;
    logic [THR_W-1:0] r_step_thr;
    logic [THR_W-1:0] r_total_thr;

    logic      w_adv;
    logic      w_fire;
    t_out_beat w_result;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_fire     = r_s1_valid && w_adv;
    assign o_in_stall = r_s1_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || w_adv) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_s1_valid || w_adv) begin
            r_s1_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_thr  <= THR_RESET;
            r_total_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEP_THR:  r_step_thr  <= i_cfg_data;
                CFG_TOTAL_THR: r_total_thr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tfz_core #(.COORD_BITS(COORD_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_beat      (r_s1_data),
        .i_step_thr  (r_step_thr),
        .i_total_thr (r_total_thr),
        .o_beat      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hw/rtl/tfz_checker.sv
// Port-level checker for the three-finger zoom recognizer, bound to the top.
// Depends on tfz_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tfz_checker import tfz_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    logic w_held;
    logic w_maybe;
    logic w_finished;
    logic w_update;
    logic w_fin_ok;
    logic w_dir_set;

    assign w_held     = o_out_valid && i_out_stall;
    assign w_maybe    = o_out_valid && o_out_data.verdict == V_MAYBE;
    assign w_finished = o_out_valid && o_out_data.verdict == V_FINISHED;
    assign w_update   = o_out_valid && o_out_data.verdict == V_UPDATE;
    assign w_fin_ok   = o_out_data.fingers == 4'd0 && o_out_data.last_dir != DIR_NONE;
    assign w_dir_set  = o_out_data.last_dir == DIR_IN || o_out_data.last_dir == DIR_OUT;

    // A stalled result beat must stay put.
    `TFZ_ASSERT(a_out_hold, w_held |=> o_out_valid && $stable(o_out_data), "stalled beat changed")

    // The result channel is empty right after reset.
    `TFZ_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "result pending after reset")

    // The gesture begins only at exactly three fingers.
    `TFZ_ASSERT(a_maybe_three, w_maybe |-> o_out_data.fingers == START_COUNT, "bad began beat")

    // A finished gesture has lifted every finger and had a direction.
    `TFZ_ASSERT(a_finished, w_finished |-> w_fin_ok, "bad finished beat")

    // An update always carries a direction.
    `TFZ_ASSERT(a_update_dir, w_update |-> w_dir_set, "update without direction")

endmodule

bind three_finger_zoom_gesture_recognizer tfz_checker u_tfz_checker (.*);
